### hw/rtl/touch_sample_average_calibrate_report_core_macros.svh
`ifndef TOUCH_SAMPLE_AVERAGE_CALIBRATE_REPORT_CORE_MACROS_SVH
`define TOUCH_SAMPLE_AVERAGE_CALIBRATE_REPORT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TSACR_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tsacr check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define TSACR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tsacr check failed");

`endif

### hw/rtl/tsacr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsacr_pkg;

  localparam int RAW_W   = 16;
  localparam int COORD_W = 12;
  localparam int TIME_W  = 32;
  localparam int PER_W   = 8;
  localparam int NUM_W   = RAW_W + COORD_W;  // (raw - lo) * 4095 fits here
  localparam int ADDR_W  = 5;
  localparam int IDX_RW  = 3;

  // Command field codes
  localparam logic CMD_POLL   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Result kind codes
  localparam logic KIND_REQ    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Register indexes
  localparam logic [IDX_RW-1:0] REG_MIN_RAW_X = 3'd0;
  localparam logic [IDX_RW-1:0] REG_MAX_RAW_X = 3'd1;
  localparam logic [IDX_RW-1:0] REG_MIN_RAW_Y = 3'd2;
  localparam logic [IDX_RW-1:0] REG_MAX_RAW_Y = 3'd3;
  localparam logic [IDX_RW-1:0] REG_INVERT_X  = 3'd4;
  localparam logic [IDX_RW-1:0] REG_INVERT_Y  = 3'd5;
  localparam logic [IDX_RW-1:0] REG_SWAP_AXES = 3'd6;
  localparam logic [IDX_RW-1:0] REG_PERIOD_MS = 3'd7;

  // Register reset values
  localparam logic [RAW_W-1:0] RST_MIN_RAW_X = 16'd1756;
  localparam logic [RAW_W-1:0] RST_MAX_RAW_X = 16'd28899;
  localparam logic [RAW_W-1:0] RST_MIN_RAW_Y = 16'd3327;
  localparam logic [RAW_W-1:0] RST_MAX_RAW_Y = 16'd30198;
  localparam logic [PER_W-1:0] RST_PERIOD_MS = 8'd10;

  typedef struct packed {
    logic [RAW_W-1:0] min_raw_x;
    logic [RAW_W-1:0] max_raw_x;
    logic [RAW_W-1:0] min_raw_y;
    logic [RAW_W-1:0] max_raw_y;
    logic             invert_x;
    logic             invert_y;
    logic             swap_axes;
    logic [PER_W-1:0] period_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_AVG,
    S_START,
    S_WAIT,
    S_PREP,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef enum logic {
    JOB_SCL_X,
    JOB_SCL_Y
  } job_t;

  typedef struct packed {
    logic capture;
    logic poll_update;
    logic accumulate;
    logic avg_store;
    logic prep;
    logic axis_y;
    logic div_start;
    logic store;
    job_t job;
    logic bump;
    logic report_update;
    logic out_load;
    logic out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic is_poll;
    logic poll_ok;
    logic pen_pressed;
    logic collecting;
    logic burst_last;
    logic div_done;
    logic changed;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/tsacr_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tsacr_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tsacr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output tsacr_pkg::cfg_t              cfg
);
  import tsacr_pkg::*;

  logic              wr_en;
  logic [IDX_RW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_raw_x <= RST_MIN_RAW_X;
      cfg.max_raw_x <= RST_MAX_RAW_X;
      cfg.min_raw_y <= RST_MIN_RAW_Y;
      cfg.max_raw_y <= RST_MAX_RAW_Y;
      cfg.invert_x  <= 1'b0;
      cfg.invert_y  <= 1'b0;
      cfg.swap_axes <= 1'b0;
      cfg.period_ms <= RST_PERIOD_MS;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_RAW_X: cfg.min_raw_x <= pwdata[RAW_W-1:0];
        REG_MAX_RAW_X: cfg.max_raw_x <= pwdata[RAW_W-1:0];
        REG_MIN_RAW_Y: cfg.min_raw_y <= pwdata[RAW_W-1:0];
        REG_MAX_RAW_Y: cfg.max_raw_y <= pwdata[RAW_W-1:0];
        REG_INVERT_X:  cfg.invert_x  <= pwdata[0];
        REG_INVERT_Y:  cfg.invert_y  <= pwdata[0];
        REG_SWAP_AXES: cfg.swap_axes <= pwdata[0];
        REG_PERIOD_MS: cfg.period_ms <= pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_RAW_X: prdata = 32'(cfg.min_raw_x);
      REG_MAX_RAW_X: prdata = 32'(cfg.max_raw_x);
      REG_MIN_RAW_Y: prdata = 32'(cfg.min_raw_y);
      REG_MAX_RAW_Y: prdata = 32'(cfg.max_raw_y);
      REG_INVERT_X:  prdata = 32'(cfg.invert_x);
      REG_INVERT_Y:  prdata = 32'(cfg.invert_y);
      REG_SWAP_AXES: prdata = 32'(cfg.swap_axes);
      REG_PERIOD_MS: prdata = 32'(cfg.period_ms);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/tsacr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tsacr_div #(
  parameter int DW = 28,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          fits;

  assign rem_sh   = {rem, quo[DW-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign fits     = (rem_sh >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[VW-1:0] : rem_sh[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tsacr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tsacr_dp #(
  parameter int NUM_SAMPLES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tsacr_pkg::cfg_t               cfg,
  input  tsacr_pkg::dp_cmd_t            cmd,
  output tsacr_pkg::dp_stat_t           stat,
  input  logic                          command,
  input  logic [tsacr_pkg::TIME_W-1:0]  now_ms,
  input  logic                          pen_pressed,
  input  logic                          host_ready,
  input  logic [tsacr_pkg::RAW_W-1:0]   raw_x,
  input  logic [tsacr_pkg::RAW_W-1:0]   raw_y,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          kind,
  output logic                          tip,
  output logic [tsacr_pkg::COORD_W-1:0] pos_x,
  output logic [tsacr_pkg::COORD_W-1:0] pos_y,
  output logic                          contact_count,
  output logic [tsacr_pkg::RAW_W-1:0]   avg_raw_x,
  output logic [tsacr_pkg::RAW_W-1:0]   avg_raw_y,
  output logic [tsacr_pkg::TIME_W-1:0]  press_count
);
  import tsacr_pkg::*;

  localparam int SUM_W  = RAW_W + $clog2(NUM_SAMPLES);
  localparam int IDX_W  = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SAMPLES - 1);
  // Average by reciprocal multiply: exact for every sum that fits SUM_W bits.
  localparam int REC_SH = SUM_W + $clog2(NUM_SAMPLES);
  localparam int REC_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + REC_W;
  localparam logic [REC_W-1:0] REC_MUL =
    REC_W'(((64'd1 << REC_SH) + 64'(NUM_SAMPLES) - 64'd1) / 64'(NUM_SAMPLES));

  // captured item
  logic              in_cmd;
  logic [TIME_W-1:0] in_now;
  logic              in_pen;
  logic              in_host;
  logic [RAW_W-1:0]  in_rx;
  logic [RAW_W-1:0]  in_ry;

  // block state
  logic [TIME_W-1:0]  next_deadline;
  logic               collecting;
  logic [IDX_W-1:0]   sample_index;
  logic [SUM_W-1:0]   sum_x_acc;
  logic [SUM_W-1:0]   sum_y_acc;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [RAW_W-1:0]   last_avg_x;
  logic [RAW_W-1:0]   last_avg_y;
  logic               prev_pen;
  logic [COORD_W-1:0] prev_x;
  logic [COORD_W-1:0] prev_y;
  logic [TIME_W-1:0]  presses;
  logic               rep_pen;

  // scaling operands
  logic [NUM_W-1:0] num;
  logic [RAW_W-1:0] span;
  logic             span_pos;
  logic             inv;

  logic              use_y;
  logic [RAW_W-1:0]  sel_raw;
  logic [RAW_W-1:0]  sel_lo;
  logic [RAW_W-1:0]  sel_hi;
  logic [RAW_W-1:0]  clamped;
  logic [RAW_W-1:0]  offset;
  logic [NUM_W-1:0]  num_next;
  logic [TIME_W-1:0] since;

  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_y;
  logic [RAW_W-1:0]   avg_x;
  logic [RAW_W-1:0]   avg_y;

  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [COORD_W-1:0] coord;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_cmd  <= command;
      in_now  <= now_ms;
      in_pen  <= pen_pressed;
      in_host <= host_ready;
      in_rx   <= raw_x;
      in_ry   <= raw_y;
    end
  end

  assign since = in_now - next_deadline;

  assign stat.is_poll     = (in_cmd == CMD_POLL);
  assign stat.poll_ok     = in_host & ~since[TIME_W-1];
  assign stat.pen_pressed = in_pen;
  assign stat.collecting  = collecting;
  assign stat.burst_last  = (sample_index == IDX_LAST);
  assign stat.div_done    = div_done;
  assign stat.changed     = (rep_pen != prev_pen) | (cur_x != prev_x) | (cur_y != prev_y);
  assign stat.out_busy    = out_valid & ~out_ready;

  assign prod_x = PROD_W'(sum_x_acc) * PROD_W'(REC_MUL);
  assign prod_y = PROD_W'(sum_y_acc) * PROD_W'(REC_MUL);
  assign avg_x  = prod_x[REC_SH +: RAW_W];
  assign avg_y  = prod_y[REC_SH +: RAW_W];

  // Pick the calibration window for the axis being scaled; swap flips it.
  always_comb begin
    use_y    = cmd.axis_y ^ cfg.swap_axes;
    sel_raw  = use_y ? last_avg_y : last_avg_x;
    sel_lo   = use_y ? cfg.min_raw_y : cfg.min_raw_x;
    sel_hi   = use_y ? cfg.max_raw_y : cfg.max_raw_x;
    if (sel_raw < sel_lo) begin
      clamped = sel_lo;
    end else if (sel_raw > sel_hi) begin
      clamped = sel_hi;
    end else begin
      clamped = sel_raw;
    end
    offset   = clamped - sel_lo;
    num_next = {offset, COORD_W'(0)} - NUM_W'(offset);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num      <= num_next;
      span     <= sel_hi - sel_lo;
      span_pos <= (sel_hi > sel_lo);
      inv      <= cmd.axis_y ? cfg.invert_y : cfg.invert_x;
    end
  end

  tsacr_div #(
    .DW (NUM_W),
    .VW (RAW_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign coord = (span_pos ? div_quo[COORD_W-1:0] : '0) ^ {COORD_W{inv}};

  always_ff @(posedge clk) begin
    if (rst) begin
      next_deadline <= '0;
      collecting    <= 1'b0;
      sample_index  <= '0;
      sum_x_acc     <= '0;
      sum_y_acc     <= '0;
      cur_x         <= '0;
      cur_y         <= '0;
      last_avg_x    <= '0;
      last_avg_y    <= '0;
      prev_pen      <= 1'b0;
      prev_x        <= '0;
      prev_y        <= '0;
      presses       <= '0;
      rep_pen       <= 1'b0;
    end else begin
      if (cmd.poll_update) begin
        next_deadline <= in_now + TIME_W'(cfg.period_ms);
        collecting    <= in_pen;
        sample_index  <= '0;
        sum_x_acc     <= '0;
        sum_y_acc     <= '0;
        rep_pen       <= 1'b0;
      end
      if (cmd.accumulate) begin
        sum_x_acc <= sum_x_acc + SUM_W'(in_rx);
        sum_y_acc <= sum_y_acc + SUM_W'(in_ry);
        if (sample_index == IDX_LAST) begin
          sample_index <= '0;
          collecting   <= 1'b0;
          rep_pen      <= 1'b1;
        end else begin
          sample_index <= sample_index + 1'b1;
        end
      end
      if (cmd.avg_store) begin
        last_avg_x <= avg_x;
        last_avg_y <= avg_y;
        sum_x_acc  <= '0;
        sum_y_acc  <= '0;
      end
      if (cmd.store) begin
        case (cmd.job)
          JOB_SCL_X: cur_x <= coord;
          JOB_SCL_Y: cur_y <= coord;
          default: ;
        endcase
      end
      if (cmd.bump && !prev_pen) begin
        presses <= presses + 1'b1;
      end
      if (cmd.report_update) begin
        prev_pen <= rep_pen;
        prev_x   <= cur_x;
        prev_y   <= cur_y;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind <= cmd.out_kind;
      if (cmd.out_kind == KIND_REPORT) begin
        tip           <= rep_pen;
        contact_count <= rep_pen;
        pos_x         <= cur_x;
        pos_y         <= cur_y;
        avg_raw_x     <= last_avg_x;
        avg_raw_y     <= last_avg_y;
        press_count   <= presses;
      end else begin
        tip           <= 1'b0;
        contact_count <= 1'b0;
        pos_x         <= '0;
        pos_y         <= '0;
        avg_raw_x     <= '0;
        avg_raw_y     <= '0;
        press_count   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tsacr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tsacr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsacr_pkg::dp_stat_t stat,
  output tsacr_pkg::dp_cmd_t  cmd
);
  import tsacr_pkg::*;

  state_t state;
  state_t state_next;
  job_t   job;
  job_t   job_next;
  logic   kind_sel;
  logic   kind_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      job      <= JOB_SCL_X;
      kind_sel <= KIND_REQ;
    end else begin
      state    <= state_next;
      job      <= job_next;
      kind_sel <= kind_sel_next;
    end
  end

  always_comb begin
    state_next    = state;
    job_next      = job;
    kind_sel_next = kind_sel;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.job       = job;
    cmd.out_kind  = kind_sel;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (stat.is_poll) begin
          if (stat.poll_ok) begin
            cmd.poll_update = 1'b1;
            if (stat.pen_pressed) begin
              kind_sel_next = KIND_REQ;
              state_next    = S_EMIT;
            end else begin
              state_next = S_CHECK;
            end
          end
        end else if (stat.collecting) begin
          cmd.accumulate = 1'b1;
          if (stat.burst_last) begin
            job_next   = JOB_SCL_X;
            state_next = S_AVG;
          end
        end
      end
      S_AVG: begin
        cmd.avg_store = 1'b1;
        state_next    = S_PREP;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) begin
          cmd.store = 1'b1;
          case (job)
            JOB_SCL_X: begin
              job_next   = JOB_SCL_Y;
              state_next = S_PREP;
            end
            default: begin
              cmd.bump   = 1'b1;
              state_next = S_CHECK;
            end
          endcase
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        cmd.axis_y = (job == JOB_SCL_Y);
        state_next = S_START;
      end
      S_CHECK: begin
        if (stat.changed) begin
          cmd.report_update = 1'b1;
          kind_sel_next     = KIND_REPORT;
          state_next        = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/touch_sample_average_calibrate_report_core.sv
// Touch front end: poll gating, sample burst averaging, calibration and reporting.
// Input channel (in_valid/in_ready): a poll beat (command 0) carries now_ms,
// pen_pressed and host_ready; a sample beat (command 1) carries one raw_x/raw_y pair.
// Output channel (out_valid/out_ready): a burst request (kind 0, all else zero)
// after an accepted pen-down poll, or a touch report (kind 1) on any change.
// Timing: a beat is taken in S_IDLE and decoded in S_DECODE. A burst request
// passes S_DECODE and S_EMIT before it is loaded into the output register, a pen-up
// report S_DECODE, S_CHECK and S_EMIT; a sample that is not the last of a burst
// frees the input again straight from S_DECODE. The last sample of a burst averages
// both sums in S_AVG with a reciprocal multiply, then runs two axis scalings on the
// one shared restoring divider (one quotient bit a cycle, 28 bits wide), then
// compares in S_CHECK and emits its report in S_EMIT. One beat is worked on at a
// time; the next is taken while a result still waits in the output register.
// Reset clears all tracking state and loads the calibration registers with
// their defaults. When the receiver stalls, the result is held in the output
// register and a following result waits in the controller until it drains.
`timescale 1ns / 1ps
`default_nettype none

module touch_sample_average_calibrate_report_core #(
  parameter int NUM_SAMPLES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsacr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [tsacr_pkg::TIME_W-1:0]  now_ms,
  input  logic                          pen_pressed,
  input  logic                          host_ready,
  input  logic [tsacr_pkg::RAW_W-1:0]   raw_x,
  input  logic [tsacr_pkg::RAW_W-1:0]   raw_y,
  // result beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kind,
  output logic                          tip,
  output logic [tsacr_pkg::COORD_W-1:0] pos_x,
  output logic [tsacr_pkg::COORD_W-1:0] pos_y,
  output logic                          contact_count,
  output logic [tsacr_pkg::RAW_W-1:0]   avg_raw_x,
  output logic [tsacr_pkg::RAW_W-1:0]   avg_raw_y,
  output logic [tsacr_pkg::TIME_W-1:0]  press_count
);
  import tsacr_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Calibration, inversion, swap, poll period; write only when idle, unenforced.
  tsacr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequence each beat: decode, then as needed accumulate, average, divide twice, compare, emit.
  tsacr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the tracking state, the shared divider and the output register.
  tsacr_dp #(
    .NUM_SAMPLES (NUM_SAMPLES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .command       (command),
    .now_ms        (now_ms),
    .pen_pressed   (pen_pressed),
    .host_ready    (host_ready),
    .raw_x         (raw_x),
    .raw_y         (raw_y),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .kind          (kind),
    .tip           (tip),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .contact_count (contact_count),
    .avg_raw_x     (avg_raw_x),
    .avg_raw_y     (avg_raw_y),
    .press_count   (press_count)
  );

endmodule

`default_nettype wire

### hw/rtl/tsacr_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "touch_sample_average_calibrate_report_core_macros.svh"

module tsacr_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic        tip,
  input logic [11:0] pos_x,
  input logic [11:0] pos_y,
  input logic        contact_count,
  input logic [15:0] avg_raw_x,
  input logic [31:0] press_count
);

  // a stalled result stays offered, its kind, tip, position and press count unchanged
  `TSACR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(tip) && $stable(pos_x) && $stable(pos_y) && $stable(press_count))
  // one beat at a time: the decode cycle follows every accepted beat
  `TSACR_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready)
  // contact count mirrors tip
  `TSACR_ASSERT_NOW(a_contact, out_valid, contact_count == tip)
  // a burst request carries zero tip, position, avg_raw_x and press count
  `TSACR_ASSERT_NOW(a_req_zero, out_valid && !kind, !tip && pos_x == 12'd0 && pos_y == 12'd0 && avg_raw_x == 16'd0 && press_count == 32'd0)

endmodule

bind touch_sample_average_calibrate_report_core tsacr_chk u_chk (.*);

`default_nettype wire

### dv/tb_touch_sample_average_calibrate_report_core.sv
`timescale 1ns / 1ps

module tb_touch_sample_average_calibrate_report_core;
  import tsacr_pkg::*;

  localparam int SAMPLES_PER_BURST = 8;
  // Longest quiet stretch with no beat moving: it must cover a burst end, the
  // settle pause, register writes and stalls.
  localparam int IDLE_LIMIT = 4000;
  // Cycles to wait after the last expected result, covering a burst end that
  // may still be dividing when the block gives nothing back.
  localparam int SETTLE_CYCLES = 150;
  localparam logic [31:0] COORD_TOP = 32'd4095;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] now_ms;
    logic              pen_pressed;
    logic              host_ready;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
  } touch_beat_t;

  typedef struct packed {
    logic               kind;
    logic               tip;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               contact_count;
    logic [RAW_W-1:0]   avg_raw_x;
    logic [RAW_W-1:0]   avg_raw_y;
    logic [TIME_W-1:0]  press_count;
  } touch_result_t;

  // Clock, reset and every block input start at a known value.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  touch_beat_t       cur_beat = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              kind;
  logic              tip;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic              contact_count;
  logic [RAW_W-1:0]  avg_raw_x;
  logic [RAW_W-1:0]  avg_raw_y;
  logic [TIME_W-1:0] press_count;

  wire               command     = cur_beat.command;
  wire [TIME_W-1:0]  now_ms      = cur_beat.now_ms;
  wire               pen_pressed = cur_beat.pen_pressed;
  wire               host_ready  = cur_beat.host_ready;
  wire [RAW_W-1:0]   raw_x       = cur_beat.raw_x;
  wire [RAW_W-1:0]   raw_y       = cur_beat.raw_y;

  always #6 clk = ~clk;

  touch_sample_average_calibrate_report_core #(
    .NUM_SAMPLES(SAMPLES_PER_BURST)
  ) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .now_ms(now_ms),
    .pen_pressed(pen_pressed), .host_ready(host_ready), .raw_x(raw_x), .raw_y(raw_y),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .tip(tip),
    .pos_x(pos_x), .pos_y(pos_y), .contact_count(contact_count),
    .avg_raw_x(avg_raw_x), .avg_raw_y(avg_raw_y), .press_count(press_count)
  );

  // ---------------------------------------------------------------------
  // Touch tracker: our own copy of calibration and tracking state, stepped
  // once per accepted input beat.
  // ---------------------------------------------------------------------
  cfg_t cal = '{RST_MIN_RAW_X, RST_MAX_RAW_X, RST_MIN_RAW_Y, RST_MAX_RAW_Y,
                1'b0, 1'b0, 1'b0, RST_PERIOD_MS};

  logic [TIME_W-1:0]  trk_deadline = '0;
  logic               trk_collecting = 1'b0;
  int unsigned        trk_count = 0;
  logic [31:0]        trk_sum_x = '0;
  logic [31:0]        trk_sum_y = '0;
  logic [COORD_W-1:0] trk_x = '0;
  logic [COORD_W-1:0] trk_y = '0;
  logic [RAW_W-1:0]   trk_avg_x = '0;
  logic [RAW_W-1:0]   trk_avg_y = '0;
  logic               trk_prev_pen = 1'b0;
  logic [COORD_W-1:0] trk_prev_x = '0;
  logic [COORD_W-1:0] trk_prev_y = '0;
  logic [TIME_W-1:0]  trk_presses = '0;

  touch_result_t results_due[$];   // results still owed by the block, oldest first
  touch_beat_t   beat_queue[$];    // beats waiting for the driver
  int unsigned   beats_queued = 0;
  int unsigned   beats_taken = 0;
  int unsigned   mismatches = 0;

  // Clamp into the window, stretch to 0..4095; a window that is empty or
  // reversed gives 0, which inversion then turns into full scale.
  function automatic logic [COORD_W-1:0] fit_axis(input logic [RAW_W-1:0] raw, lo, hi,
                                                   input logic inv);
    logic [31:0] v;
    logic [31:0] r;
    v = '0;
    r = raw;
    if (hi > lo) begin
      if (raw < lo) r = lo;
      if (raw > hi) r = hi;
      v = (r - lo) * COORD_TOP / (hi - lo);
    end
    if (inv) v = COORD_TOP - v;
    return v[COORD_W-1:0];
  endfunction

  // Owe a touch report only when the pen state or the position moved.
  function automatic void report_if_moved(input logic down);
    touch_result_t r;
    if (down == trk_prev_pen && trk_x == trk_prev_x && trk_y == trk_prev_y) return;
    trk_prev_pen = down;
    trk_prev_x = trk_x;
    trk_prev_y = trk_y;
    r = '{KIND_REPORT, down, trk_x, trk_y, down, trk_avg_x, trk_avg_y, trk_presses};
    results_due.push_back(r);
  endfunction

  function automatic void track_beat(input touch_beat_t b);
    touch_result_t     req;
    logic [TIME_W-1:0] lag;
    req = '0;
    req.kind = KIND_REQ;
    lag = b.now_ms - trk_deadline;
    if (b.command == CMD_POLL) begin
      // Drop polls from a host that is not ready, and early ones.
      if (!b.host_ready || lag[TIME_W-1]) return;
      trk_deadline = b.now_ms + TIME_W'(cal.period_ms);
      // An accepted poll always throws away a burst in progress.
      trk_collecting = 1'b0;
      trk_count = 0;
      trk_sum_x = '0;
      trk_sum_y = '0;
      if (b.pen_pressed) begin
        trk_collecting = 1'b1;
        results_due.push_back(req);
      end else begin
        report_if_moved(1'b0);
      end
    end else if (trk_collecting) begin
      trk_sum_x += b.raw_x;
      trk_sum_y += b.raw_y;
      trk_count++;
      if (trk_count == SAMPLES_PER_BURST) begin
        trk_collecting = 1'b0;
        trk_count = 0;
        trk_avg_x = RAW_W'(trk_sum_x / SAMPLES_PER_BURST);
        trk_avg_y = RAW_W'(trk_sum_y / SAMPLES_PER_BURST);
        trk_sum_x = '0;
        trk_sum_y = '0;
        if (cal.swap_axes) begin
          trk_x = fit_axis(trk_avg_y, cal.min_raw_y, cal.max_raw_y, cal.invert_x);
          trk_y = fit_axis(trk_avg_x, cal.min_raw_x, cal.max_raw_x, cal.invert_y);
        end else begin
          trk_x = fit_axis(trk_avg_x, cal.min_raw_x, cal.max_raw_x, cal.invert_x);
          trk_y = fit_axis(trk_avg_y, cal.min_raw_y, cal.max_raw_y, cal.invert_y);
        end
        if (!trk_prev_pen) trk_presses++;
        report_if_moved(1'b1);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sampling at the rising edge: check result beats, then step the tracker
  // on input beats. A result never belongs to the beat taken at that edge.
  // ---------------------------------------------------------------------
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  always @(posedge clk) begin
    touch_result_t seen;
    touch_result_t want;
    seen = '{kind, tip, pos_x, pos_y, contact_count, avg_raw_x, avg_raw_y, press_count};
    in_fire <= !rst && in_valid && in_ready;
    out_fire <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, kind %0d", $time, seen.kind);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", want.kind, seen.kind);
          check_field("tip", want.tip, seen.tip);
          check_field("pos_x", want.pos_x, seen.pos_x);
          check_field("pos_y", want.pos_y, seen.pos_y);
          check_field("contact_count", want.contact_count, seen.contact_count);
          check_field("avg_raw_x", want.avg_raw_x, seen.avg_raw_x);
          check_field("avg_raw_y", want.avg_raw_y, seen.avg_raw_y);
          check_field("press_count", want.press_count, seen.press_count);
        end
      end
      if (in_valid && in_ready) begin
        track_beat(cur_beat);
        beats_taken++;
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver and receiver, both moving at the falling edge. Each draws a random wait
  // after every beat, with calm stretches of no wait toggled now and then.
  // ---------------------------------------------------------------------
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_fire) begin
      // Only move on once the current beat has gone; hold it otherwise.
      if (in_fire) begin
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        send_gap = draw_wait(send_calm);
      end
      if (send_gap == 0 && beat_queue.size() != 0) begin
        cur_beat <= beat_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        recv_stall = draw_wait(recv_calm);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_ready <= (recv_stall == 0);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers. Fields a beat does not use still carry random values.
  // ---------------------------------------------------------------------
  task automatic add_poll(input logic [TIME_W-1:0] t, input logic pen, host);
    beat_queue.push_back('{CMD_POLL, t, pen, host, RAW_W'($urandom), RAW_W'($urandom)});
    beats_queued++;
  endtask

  task automatic add_sample(input logic [RAW_W-1:0] x, y);
    beat_queue.push_back('{CMD_SAMPLE, TIME_W'($urandom), 1'($urandom), 1'($urandom), x, y});
    beats_queued++;
  endtask

  // Hold until every queued beat has gone and every result has arrived.
  task automatic wait_results();
    while (beats_taken != beats_queued || results_due.size() != 0) @(posedge clk);
  endtask

  // As above, then let a burst end that owes nothing finish dividing.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [IDX_RW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MIN_RAW_X: cal.min_raw_x = val[RAW_W-1:0];
      REG_MAX_RAW_X: cal.max_raw_x = val[RAW_W-1:0];
      REG_MIN_RAW_Y: cal.min_raw_y = val[RAW_W-1:0];
      REG_MAX_RAW_Y: cal.max_raw_y = val[RAW_W-1:0];
      REG_INVERT_X:  cal.invert_x = val[0];
      REG_INVERT_Y:  cal.invert_y = val[0];
      REG_SWAP_AXES: cal.swap_axes = val[0];
      REG_PERIOD_MS: cal.period_ms = val[PER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cal(input cfg_t c);
    write_reg(REG_MIN_RAW_X, 32'(c.min_raw_x));
    write_reg(REG_MAX_RAW_X, 32'(c.max_raw_x));
    write_reg(REG_MIN_RAW_Y, 32'(c.min_raw_y));
    write_reg(REG_MAX_RAW_Y, 32'(c.max_raw_y));
    write_reg(REG_INVERT_X, 32'(c.invert_x));
    write_reg(REG_INVERT_Y, 32'(c.invert_y));
    write_reg(REG_SWAP_AXES, 32'(c.swap_axes));
    write_reg(REG_PERIOD_MS, 32'(c.period_ms));
  endtask

  function automatic cfg_t make_cal(input logic [RAW_W-1:0] lo_x, hi_x, lo_y, hi_y,
                                    input logic inv_x, inv_y, swap,
                                    input logic [PER_W-1:0] per);
    return '{lo_x, hi_x, lo_y, hi_y, inv_x, inv_y, swap, per};
  endfunction

  // Random frames: mostly on-time polls with full bursts around a wandering
  // centre, plus early polls, long forward jumps in time, host stalls,
  // short or overlong bursts and stray samples.
  logic [TIME_W-1:0] poll_clock = '0;
  logic              pen_state = 1'b0;
  logic [RAW_W-1:0]  centre_x = 16'h4000;
  logic [RAW_W-1:0]  centre_y = 16'h8000;

  task automatic run_random(input int unsigned want);
    int unsigned       useful;
    int unsigned       n;
    int unsigned       k;
    int unsigned       jitter;
    logic [TIME_W-1:0] dt;
    logic              host;
    bit                wild;
    useful = 0;
    while (useful < want) begin
      if ($urandom_range(0, 19) == 0) add_sample(RAW_W'($urandom), RAW_W'($urandom));
      case ($urandom_range(0, 15))
        0: dt = $urandom_range(0, cal.period_ms);
        1: dt = $urandom_range(0, 32'h7FFF_FFFF);
        default: dt = cal.period_ms + $urandom_range(0, 4);
      endcase
      poll_clock += dt;
      host = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 3) == 0) pen_state = !pen_state;
      add_poll(poll_clock, pen_state, host);
      if (host) useful++;
      if (host && pen_state) begin
        k = $urandom_range(0, 9);
        n = (k == 0) ? $urandom_range(1, 7) : (k == 1) ? 10 : SAMPLES_PER_BURST;
        if ($urandom_range(0, 2) == 0) begin
          centre_x = RAW_W'($urandom);
          centre_y = RAW_W'($urandom);
        end
        wild = ($urandom_range(0, 3) == 0);
        jitter = $urandom_range(0, 1) ? 63 : 0;
        for (int i = 0; i < n; i++) begin
          if (wild) add_sample(RAW_W'($urandom), RAW_W'($urandom));
          else add_sample(centre_x + RAW_W'($urandom_range(0, jitter)),
                          centre_y + RAW_W'($urandom_range(0, jitter)));
        end
        useful += n;
      end
      // Now and then stop sending until everything owed has come back.
      if ($urandom_range(0, 39) == 0) wait_results();
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    cfg_t plan[$];
    logic [RAW_W-1:0] a;
    logic [RAW_W-1:0] b;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under reset calibration.
    add_sample(16'h1234, 16'h5678);                 // sample with no burst open
    add_poll(32'd0, 1'b1, 1'b0);                    // host not ready
    add_poll(32'd0, 1'b0, 1'b1);                    // accepted, nothing changed
    add_poll(32'd5, 1'b1, 1'b1);                    // early
    add_poll(32'd10, 1'b1, 1'b1);                   // burst request
    repeat (3) add_sample(16'hFFFF, 16'hFFFF);
    add_poll(32'd20, 1'b1, 1'b1);                   // cancel and restart the burst
    for (int i = 0; i < SAMPLES_PER_BURST; i++)
      add_sample((i % 2) ? 16'hFFFF : 16'h0000, 16'h0000);
    add_poll(32'hFFFF_FFFF, 1'b0, 1'b1);            // just before the deadline, wrapped: early
    add_poll(32'h8000_001E, 1'b0, 1'b1);            // exactly half the range ahead
    add_poll(32'h8000_001D, 1'b0, 1'b1);            // just in time: pen up report
    add_poll(32'hFFFF_FFFF, 1'b0, 1'b1);            // deadline wraps past zero
    add_poll(32'd9, 1'b0, 1'b1);
    poll_clock = 32'd9;
    run_random(100);
    settle();

    // Window extremes, empty and reversed windows, zero and full periods.
    plan.push_back(make_cal(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0, 8'd1));
    plan.push_back(make_cal(RST_MIN_RAW_X, RST_MAX_RAW_X, RST_MIN_RAW_Y, RST_MAX_RAW_Y,
                            1'b0, 1'b1, 1'b1, 8'd255));
    plan.push_back(make_cal(16'd1000, 16'd1000, 16'd40000, 16'd20000,
                            1'b1, 1'b0, 1'b0, 8'd0));
    plan.push_back(make_cal(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b1, 8'd10));
    repeat (3) begin
      a = RAW_W'($urandom);
      b = RAW_W'($urandom);
      plan.push_back(make_cal(a, b, RAW_W'($urandom_range(0, 16'h7FFF)),
                              RAW_W'($urandom_range(16'h8000, 16'hFFFF)),
                              1'($urandom), 1'($urandom), 1'($urandom),
                              PER_W'($urandom_range(1, 255))));
    end

    foreach (plan[p]) begin
      apply_cal(plan[p]);
      run_random(100);
      settle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tsacr_pkg.sv
hw/rtl/tsacr_regs.sv
hw/rtl/tsacr_div.sv
hw/rtl/tsacr_dp.sv
hw/rtl/tsacr_ctrl.sv
hw/rtl/touch_sample_average_calibrate_report_core.sv
hw/rtl/tsacr_chk.sv
dv/tb_touch_sample_average_calibrate_report_core.sv
